@@ rtl/acpu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_pkg: shared types and codes for the accumulator machine execute core
// Opcodes, status codes, field types and default sizes.
// ----------------------------------------------------------------------------
package acpu_pkg;

	// Default sizes
	localparam int MEM_DEPTH_DEF = 256;
	localparam int ACC_WIDTH_DEF = 32;

	// Fixed field widths
	localparam int OP_W   = 8;
	localparam int ARG_W  = 8;
	localparam int PC_W   = 8;
	localparam int BYTE_W = 8;
	localparam int ACCO_W = 32;

	typedef logic [OP_W-1:0]   opcode_t;
	typedef logic [ARG_W-1:0]  operand_t;
	typedef logic [PC_W-1:0]   pc_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [1:0]        status_t;

	// Opcodes
	localparam opcode_t OP_LDM  = 8'd0;
	localparam opcode_t OP_LDI  = 8'd1;
	localparam opcode_t OP_ST   = 8'd2;
	localparam opcode_t OP_ADD  = 8'd3;
	localparam opcode_t OP_SUB  = 8'd4;
	localparam opcode_t OP_MUL  = 8'd5;
	localparam opcode_t OP_DIV  = 8'd6;
	localparam opcode_t OP_INC  = 8'd7;
	localparam opcode_t OP_DEC  = 8'd8;
	localparam opcode_t OP_AND  = 8'd9;
	localparam opcode_t OP_OR   = 8'd10;
	localparam opcode_t OP_NOT  = 8'd11;
	localparam opcode_t OP_JMP  = 8'd12;
	localparam opcode_t OP_JZ   = 8'd13;
	localparam opcode_t OP_JNZ  = 8'd14;
	localparam opcode_t OP_JGT  = 8'd15;
	localparam opcode_t OP_JLT  = 8'd16;
	localparam opcode_t OP_JGE  = 8'd17;
	localparam opcode_t OP_JLE  = 8'd18;
	localparam opcode_t OP_HALT = 8'd19;

	// Result status
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_HALTED  = 2'd1;
	localparam status_t ST_DIVZERO = 2'd2;
	localparam status_t ST_ILLEGAL = 2'd3;

endpackage

@@ rtl/acpu_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_if: item channels of the execute core
// Instruction channel (opcode, operand) and result channel (pc, acc, status).
// ----------------------------------------------------------------------------
interface acpu_in_if import acpu_pkg::*; ();
	logic     valid;
	logic     ready;
	opcode_t  opcode;
	operand_t operand;

	modport source(output valid, output opcode, output operand, input ready);
	modport sink(input valid, input opcode, input operand, output ready);
endinterface

interface acpu_out_if import acpu_pkg::*; ();
	logic               valid;
	logic               ready;
	pc_t                next_pc;
	logic signed [31:0] acc_value;
	status_t            status;

	modport source(output valid, output next_pc, output acc_value, output status,
		input ready);
	modport sink(input valid, input next_pc, input acc_value, input status,
		output ready);
endinterface

@@ rtl/acpu_dmem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_dmem: byte-wide data memory
// One write and one registered read per cycle. Per-entry valid bits make
// every entry read as zero after reset until it is first written.
// ----------------------------------------------------------------------------
module acpu_dmem import acpu_pkg::*; #(
	parameter int MEM_DEPTH = MEM_DEPTH_DEF,
	parameter int AW        = $clog2(MEM_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  byte_t         wr_data,
	output byte_t         rd_data
);

	byte_t                mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] vld_q;
	byte_t                rd_data_q;
	logic                 rd_vld_q;

	// Storage array and read register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Written-once marks, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

@@ rtl/acpu_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_div: iterative signed-by-unsigned divider
// Signed ACC_WIDTH-bit dividend over a nonzero unsigned byte, truncating
// toward zero. Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acpu_div import acpu_pkg::*; #(
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ACC_WIDTH-1:0] dividend,
	input  byte_t                divisor,
	output logic                 done,
	output logic [ACC_WIDTH-1:0] quotient
);

	localparam int CW = $clog2(ACC_WIDTH);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic                 neg_q;
	byte_t                dvs_q;
	byte_t                rem_q;
	logic [ACC_WIDTH-1:0] quo_q;

	logic [BYTE_W:0]      shifted;
	logic                 fits;
	byte_t                rem_nx;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q, quo_q[ACC_WIDTH-1]};
		fits    = shifted >= {1'b0, dvs_q};
		rem_nx  = fits ? BYTE_W'(shifted - {1'b0, dvs_q}) : shifted[BYTE_W-1:0];
	end

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(ACC_WIDTH - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Datapath: quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[ACC_WIDTH-1];
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend[ACC_WIDTH-1] ? (~dividend + 1'b1) : dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[ACC_WIDTH-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

@@ rtl/accumulator_cpu_execute_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_core: accumulator machine instruction execute
// Executes one (opcode, operand) item per instruction against the
// accumulator, pc and data memory, returning next pc, accumulator, status.
//
//   channel  direction  handshake      payload
//   inst     in         valid / ready  opcode[7:0], operand[7:0]
//   result   out        valid / ready  next_pc[7:0], acc_value[31:0], status[1:0]
//
// An item is taken only in the idle state, where the data memory read starts;
// the execute step then executes it and holds until the result slot is free
// for write-back. A divide by a nonzero byte waits in the divide state for the
// bit-serial divider. After reset the control and architectural registers take
// their reset values at once; memory entries read as zero until written.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute_core import acpu_pkg::*; #(
	parameter int MEM_DEPTH = MEM_DEPTH_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	acpu_in_if.sink    inst,
	acpu_out_if.source result
);

	localparam int AW = $clog2(MEM_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;

	// Low 32 bits of an accumulator value, zero-extended when narrower
	function automatic logic [ACCO_W-1:0] acc_lo(input logic [ACC_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[ACCO_W-1:0];
	endfunction

	logic [1:0]           state_q;
	logic [ACC_WIDTH-1:0] acc_q;
	pc_t                  pc_q;
	logic                 halt_q;
	opcode_t              op_s1;
	operand_t             arg_s1;

	logic                 out_valid_q;
	pc_t                  out_pc_q;
	logic [ACCO_W-1:0]    out_acc_q;
	status_t              out_status_q;

	logic [AW-1:0]        addr_map [256];
	byte_t                m_byte;
	logic                 accept;
	logic                 out_free;

	logic [ACC_WIDTH-1:0] m_ext;
	logic [ACC_WIDTH+7:0] mul_full;
	logic [ACC_WIDTH-1:0] acc_nx;
	pc_t                  npc;
	status_t              status_nx;
	logic                 take;
	logic                 halt_set;
	logic                 div_go;
	logic                 st_we;
	logic                 is_zero;
	logic                 is_neg;
	logic                 commit;
	logic                 div_fin;
	logic                 div_done;
	logic [ACC_WIDTH-1:0] div_quo;

	// Operand to memory address, modulo the memory depth
	for (genvar gi = 0; gi < 256; gi++) begin : g_amap
		localparam int AM = gi % MEM_DEPTH;
		assign addr_map[gi] = AW'(AM);
	end

	assign accept   = inst.valid && inst.ready;
	assign out_free = !out_valid_q || result.ready;

	acpu_dmem #(
		.MEM_DEPTH(MEM_DEPTH),
		.AW       (AW)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(addr_map[inst.operand]),
		.wr_en  (st_we && commit),
		.wr_addr(addr_map[arg_s1]),
		.wr_data(acc_q[BYTE_W-1:0]),
		.rd_data(m_byte)
	);

	acpu_div #(
		.ACC_WIDTH(ACC_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_EXEC && div_go),
		.dividend(acc_q),
		.divisor (m_byte),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Execute: decode the held instruction against acc and the memory byte
	assign m_ext    = ACC_WIDTH'(m_byte);
	assign mul_full = (ACC_WIDTH+8)'(acc_q) * (ACC_WIDTH+8)'(m_byte);
	assign is_zero  = (acc_q == '0);
	assign is_neg   = acc_q[ACC_WIDTH-1];

	always_comb begin
		acc_nx    = acc_q;
		npc       = pc_q + 1'b1;
		status_nx = ST_OK;
		take      = 1'b0;
		halt_set  = 1'b0;
		div_go    = 1'b0;
		st_we     = 1'b0;
		if (halt_q) begin
			npc       = pc_q;
			status_nx = ST_HALTED;
		end else begin
			case (op_s1)
				OP_LDM: acc_nx = m_ext;
				OP_LDI: acc_nx = ACC_WIDTH'(arg_s1);
				OP_ST:  st_we  = 1'b1;
				OP_ADD: acc_nx = acc_q + m_ext;
				OP_SUB: acc_nx = acc_q - m_ext;
				OP_MUL: acc_nx = mul_full[ACC_WIDTH-1:0];
				OP_DIV: begin
					if (m_byte == '0) begin
						status_nx = ST_DIVZERO;
					end else begin
						div_go = 1'b1;
					end
				end
				OP_INC: acc_nx = acc_q + 1'b1;
				OP_DEC: acc_nx = acc_q - 1'b1;
				OP_AND: acc_nx = acc_q & m_ext;
				OP_OR:  acc_nx = acc_q | m_ext;
				OP_NOT: acc_nx = ~acc_q;
				OP_JMP: take   = 1'b1;
				OP_JZ:  take   = is_zero;
				OP_JNZ: take   = !is_zero;
				OP_JGT: take   = !is_neg && !is_zero;
				OP_JLT: take   = is_neg;
				OP_JGE: take   = !is_neg;
				OP_JLE: take   = is_neg || is_zero;
				OP_HALT: begin
					halt_set  = 1'b1;
					npc       = pc_q;
					status_nx = ST_HALTED;
				end
				default: begin
					halt_set  = 1'b1;
					npc       = pc_q;
					status_nx = ST_ILLEGAL;
				end
			endcase
			if (take) begin
				npc = arg_s1;
			end
		end
	end

	// Write-back from the execute step, once the result slot is free
	assign commit  = (state_q == S_EXEC) && !div_go && out_free;
	// Write-back of a finished divide, once the result slot is free
	assign div_fin = (state_q == S_DIV) && div_done && out_free;

	// Control: sequencer, architectural registers, result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= ACC_WIDTH'(1);
			pc_q        <= '0;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result slot: a new item wins over the drain of the old one
			if (commit || div_fin) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (div_go) begin
						state_q <= S_DIV;
					end else if (out_free) begin
						acc_q   <= acc_nx;
						pc_q    <= npc;
						halt_q  <= halt_q || halt_set;
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_fin) begin
						acc_q   <= div_quo;
						pc_q    <= pc_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Instruction capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= inst.opcode;
			arg_s1 <= inst.operand;
		end
		if (commit) begin
			out_pc_q     <= npc;
			out_acc_q    <= acc_lo(acc_nx);
			out_status_q <= status_nx;
		end else if (div_fin) begin
			out_pc_q     <= pc_q + 1'b1;
			out_acc_q    <= acc_lo(div_quo);
			out_status_q <= ST_OK;
		end
	end

	assign inst.ready       = (state_q == S_IDLE);
	assign result.valid     = out_valid_q;
	assign result.next_pc   = out_pc_q;
	assign result.acc_value = out_acc_q;
	assign result.status    = out_status_q;

endmodule

@@ verif/accumulator_cpu_execute_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_core_tb: self-checking bench for the execute core
// Runs a short directed program, then about six hundred random well-formed
// instructions, then ends the program with a halt or an illegal opcode and
// sends more items to check that the core holds. Each result is checked against
// an in-bench model or a pinned directed result. Both channels idle at random.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute_core_tb import acpu_pkg::*; ();

	localparam int N_DIRECTED   = 27;
	localparam int RAND_ITEMS   = 600;
	localparam int TAIL_ITEMS   = 20;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		pc_t         pc;
		logic [31:0] acc;
		status_t     status;
	} exec_result_t;

	// One row of the directed program; pinned rows carry their own result
	typedef struct packed {
		opcode_t     op;
		operand_t    arg;
		logic        pinned;
		pc_t         pc;
		logic [31:0] acc;
		status_t     status;
	} program_row_t;

	logic clk;
	logic arst_n;

	acpu_in_if  inst_ch();
	acpu_out_if res_ch();

	accumulator_cpu_execute_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.inst   (inst_ch),
		.result (res_ch)
	);

	// Machine state as the bench sees it
	logic [31:0] acc_model;
	pc_t         pc_model;
	byte_t       mem_model [256];
	logic        halted_model;

	exec_result_t pending_results [$];
	int           mismatch_count;
	bit           src_quiet;
	bit           snk_quiet;

	// Directed program: reset values, divide by zero, pc wrap, every opcode but halt,
	// accumulator driven to its most negative and most positive values
	program_row_t directed_rows [N_DIRECTED] = '{
		'{OP_LDM, 8'hFF, 1'b1, 8'h01, 32'h0000_0000, ST_OK},
		'{OP_DIV, 8'h00, 1'b1, 8'h02, 32'h0000_0000, ST_DIVZERO},
		'{OP_JZ,  8'h40, 1'b1, 8'h40, 32'h0000_0000, ST_OK},
		'{OP_DEC, 8'h00, 1'b1, 8'h41, 32'hFFFF_FFFF, ST_OK},
		'{OP_JLT, 8'hFF, 1'b1, 8'hFF, 32'hFFFF_FFFF, ST_OK},
		'{OP_INC, 8'h00, 1'b1, 8'h00, 32'h0000_0000, ST_OK},
		'{OP_JLE, 8'h20, 1'b1, 8'h20, 32'h0000_0000, ST_OK},
		'{OP_LDI, 8'h08, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_ST,  8'h08, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_LDI, 8'h80, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_ST,  8'hFF, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_MUL, 8'hFF, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_MUL, 8'hFF, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_MUL, 8'hFF, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_JGT, 8'h30, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_MUL, 8'h08, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_JGE, 8'h50, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_DEC, 8'h00, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_INC, 8'h00, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_DIV, 8'hFF, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_ADD, 8'hFF, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_SUB, 8'h08, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_OR,  8'hFF, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_AND, 8'h08, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_NOT, 8'h00, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_JNZ, 8'h00, 1'b0, 8'h00, 32'h0, ST_OK},
		'{OP_JMP, 8'hAB, 1'b0, 8'h00, 32'h0, ST_OK}
	};

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Executes one instruction on the bench state, returns the result item
	function automatic exec_result_t execute_inst(opcode_t op, operand_t arg);
		exec_result_t r;
		logic [31:0]  a;
		logic [31:0]  m;
		logic [31:0]  mag;
		logic [31:0]  quo;
		logic         take;
		a        = acc_model;
		m        = {24'd0, mem_model[arg]};
		take     = 1'b0;
		r.status = ST_OK;
		r.pc     = pc_model + 8'd1;
		if (halted_model) begin
			r.status = ST_HALTED;
			r.pc     = pc_model;
		end else begin
			case (op)
				OP_LDM: a = m;
				OP_LDI: a = {24'd0, arg};
				OP_ST:  mem_model[arg] = a[7:0];
				OP_ADD: a = a + m;
				OP_SUB: a = a - m;
				OP_MUL: a = a * m;
				OP_DIV: begin
					// signed dividend, unsigned byte divisor, truncate toward zero
					if (m == 32'd0) begin
						r.status = ST_DIVZERO;
					end else begin
						mag = a[31] ? -a : a;
						quo = mag / m;
						a   = a[31] ? -quo : quo;
					end
				end
				OP_INC: a = a + 32'd1;
				OP_DEC: a = a - 32'd1;
				OP_AND: a = a & m;
				OP_OR:  a = a | m;
				OP_NOT: a = ~a;
				OP_JMP: take = 1'b1;
				OP_JZ:  take = (a == 32'd0);
				OP_JNZ: take = (a != 32'd0);
				OP_JGT: take = !a[31] && (a != 32'd0);
				OP_JLT: take = a[31];
				OP_JGE: take = !a[31];
				OP_JLE: take = a[31] || (a == 32'd0);
				OP_HALT: begin
					halted_model = 1'b1;
					r.status     = ST_HALTED;
					r.pc         = pc_model;
				end
				default: begin
					halted_model = 1'b1;
					r.status     = ST_ILLEGAL;
					r.pc         = pc_model;
				end
			endcase
			if (take) r.pc = arg;
			acc_model = a;
			pc_model  = r.pc;
		end
		r.acc = acc_model;
		return r;
	endfunction

	// Gap length: mostly none, some short, a few long
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Operands lean on a few addresses at each end so loads see stored bytes
	function automatic operand_t pick_operand();
		if ($urandom_range(0, 1) == 1)
			return operand_t'($urandom_range(0, 7) + ($urandom_range(0, 1) == 1 ? 248 : 0));
		return operand_t'($urandom_range(0, 255));
	endfunction

	function automatic opcode_t pick_opcode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) return OP_ST;
		if (r < 20) return OP_LDI;
		return opcode_t'($urandom_range(0, OP_HALT - 1));
	endfunction

	// Drive one instruction item and record what it should produce
	task automatic send_inst(opcode_t op, operand_t arg, logic pinned, exec_result_t pinned_res);
		int           gap;
		exec_result_t pred;
		gap = pick_gap(src_quiet);
		if (gap > 0) begin
			inst_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		inst_ch.valid   <= 1'b1;
		inst_ch.opcode  <= op;
		inst_ch.operand <= arg;
		do @(posedge clk); while (!inst_ch.ready);
		pred = execute_inst(op, arg);
		pending_results.push_back(pinned ? pinned_res : pred);
	endtask

	task automatic check_result(pc_t pc, logic [31:0] acc, status_t status);
		exec_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result pc=%02h acc=%08h status=%0d",
				pc, acc, status));
			return;
		end
		want = pending_results.pop_front();
		if (pc !== want.pc)
			report_mismatch($sformatf("next_pc %02h, want %02h", pc, want.pc));
		if (acc !== want.acc)
			report_mismatch($sformatf("acc_value %08h, want %08h", acc, want.acc));
		if (status !== want.status)
			report_mismatch($sformatf("status %0d, want %0d", status, want.status));
	endtask

	// Result side: check accepted items, stall ready at random
	initial begin
		int stall;
		int tick;
		stall     = 0;
		tick      = 0;
		snk_quiet = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				check_result(res_ch.next_pc, res_ch.acc_value, res_ch.status);
			tick++;
			if (tick % 64 == 0) snk_quiet = ($urandom_range(0, 3) == 0);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
				if (!snk_quiet && $urandom_range(0, 99) < 30) stall = pick_gap(1'b0);
			end
		end
	end

	// Watchdog: too long without any accepted item on either channel
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((inst_ch.valid && inst_ch.ready) || (res_ch.valid && res_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("FAIL");
		$finish;
	end

	// Stimulus
	initial begin
		exec_result_t pinned_res;
		exec_result_t none;
		program_row_t row;
		opcode_t      op;

		arst_n          <= 1'b0;
		inst_ch.valid   <= 1'b0;
		inst_ch.opcode  <= OP_LDM;
		inst_ch.operand <= 8'h00;
		mismatch_count  = 0;
		src_quiet       = 1'b0;
		none            = '0;

		// machine state after reset
		acc_model    = 32'd1;
		pc_model     = 8'h00;
		halted_model = 1'b0;
		foreach (mem_model[i]) mem_model[i] = 8'h00;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed program
		for (int i = 0; i < N_DIRECTED; i++) begin
			row               = directed_rows[i];
			pinned_res.pc     = row.pc;
			pinned_res.acc    = row.acc;
			pinned_res.status = row.status;
			send_inst(row.op, row.arg, row.pinned, pinned_res);
		end

		// random program, no halting opcodes
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 50 == 0) src_quiet = ($urandom_range(0, 3) == 0);
			send_inst(pick_opcode(), pick_operand(), 1'b0, none);
		end

		// end the program, then check that further items leave the machine state unchanged
		src_quiet = 1'b0;
		if ($urandom_range(0, 1) == 1)
			op = OP_HALT;
		else
			op = opcode_t'($urandom_range(OP_HALT + 1, 255));
		send_inst(op, pick_operand(), 1'b0, none);
		send_inst(8'hFF, 8'hFF, 1'b0, none);
		for (int i = 0; i < TAIL_ITEMS; i++)
			send_inst(opcode_t'($urandom_range(0, 255)), operand_t'($urandom_range(0, 255)),
				1'b0, none);
		inst_ch.valid <= 1'b0;

		// drain, then let any stray result show up
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
